FILE: sv/psev_pkg.sv
`timescale 1ns / 1ps
// psev_pkg: request and operator codes, state types and default sizes
// shared by the postfix evaluator modules; depends on nothing

package psev_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int VAR_COUNT_DEF   = 64;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int REQ_W = 3;
  localparam int OP_W  = 5;
  localparam int IDX_W = 6;
  localparam int EXT_W = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_CONST = 3'd0,
    REQ_PUSH_VAR   = 3'd1,
    REQ_APPLY      = 3'd2,
    REQ_FINISH     = 3'd3,
    REQ_WRITE_VAR  = 3'd4,
    REQ_READ_VAR   = 3'd5
  } req_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MUL  = 5'd2,
    OP_DIV  = 5'd3,
    OP_AND  = 5'd4,
    OP_OR   = 5'd5,
    OP_MOD  = 5'd6,
    OP_SHR  = 5'd7,
    OP_SHL  = 5'd8,
    OP_XOR  = 5'd9,
    OP_LOR  = 5'd10,
    OP_LAND = 5'd11,
    OP_EQ   = 5'd12,
    OP_NE   = 5'd13,
    OP_GT   = 5'd14,
    OP_LT   = 5'd15,
    OP_GE   = 5'd16,
    OP_LE   = 5'd17
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSHV,
    ST_RDV,
    ST_FIN,
    ST_POPB,
    ST_POPA,
    ST_MULDIV
  } st_t;

  typedef enum logic [1:0] {
    MD_MUL,
    MD_DIV,
    MD_MOD
  } md_op_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_RUN,
    MD_FIX
  } md_state_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_req_t;

endpackage

FILE: sv/psev_if.sv
`timescale 1ns / 1ps
// psev_in_if / psev_out_if: valid-ready channels of the postfix evaluator
// no dependencies

interface psev_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        req_type;
  logic signed [31:0] operand_value;
  logic [5:0]        var_index;
  logic [4:0]        op_code;

  modport source (output valid, req_type, operand_value, var_index, op_code,
                  input ready);
  modport sink   (input valid, req_type, operand_value, var_index, op_code,
                  output ready);
endinterface

interface psev_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               overflow_seen;
  logic               underflow_seen;

  modport source (output valid, result_value, overflow_seen, underflow_seen,
                  input ready);
  modport sink   (input valid, result_value, overflow_seen, underflow_seen,
                  output ready);
endinterface

FILE: sv/psev_ram.sv
`timescale 1ns / 1ps
// psev_ram: generic single-write, single-read ram with registered read
// no dependencies

module psev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/psev_muldiv.sv
`timescale 1ns / 1ps
// psev_muldiv: iterative shift-add multiplier and restoring divider,
// one bit per cycle; depends on psev_pkg

module psev_muldiv #(
  parameter int DATA_WIDTH = psev_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psev_pkg::md_req_t     req,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] result
);
  import psev_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH);
  localparam int DW = DATA_WIDTH;

  md_state_t     state_r, state_nxt;
  md_op_t        op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] acc_r, acc_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic          negq_r, negq_nxt;
  logic          nega_r, nega_nxt;
  logic          zero_r, zero_nxt;
  logic [DW-1:0] res_r, res_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic [DW-1:0] mag_a, mag_b;

  assign mag_a = a[DW-1] ? DW'(-a) : a;
  assign mag_b = b[DW-1] ? DW'(-b) : b;
  assign trial = {acc_r, q_r[DW-1]} - {1'b0, d_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MD_IDLE: if (req.start) state_nxt = MD_RUN;
      MD_RUN:  if (cnt_r == '0) state_nxt = MD_FIX;
      MD_FIX:  state_nxt = MD_IDLE;
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_comb begin
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    negq_nxt = negq_r;
    nega_nxt = nega_r;
    zero_nxt = zero_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;
    unique case (state_r)
      MD_IDLE: begin
        if (req.start) begin
          op_nxt   = req.op;
          cnt_nxt  = CW'(DW - 1);
          acc_nxt  = '0;
          negq_nxt = a[DW-1] ^ b[DW-1];
          nega_nxt = a[DW-1];
          zero_nxt = (b == '0);
          if (req.op == MD_MUL) begin
            q_nxt = b;
            d_nxt = a;
          end else begin
            q_nxt = mag_a;
            d_nxt = mag_b;
          end
        end
      end
      MD_RUN: begin
        cnt_nxt = cnt_r - CW'(1);
        if (op_r == MD_MUL) begin
          acc_nxt = q_r[0] ? acc_r + d_r : acc_r;
          d_nxt   = d_r << 1;
          q_nxt   = q_r >> 1;
        end else begin
          // restoring step: keep the difference when it did not borrow
          if (!trial[DW]) begin
            acc_nxt = trial[DW-1:0];
          end else begin
            acc_nxt = {acc_r[DW-2:0], q_r[DW-1]};
          end
          q_nxt = {q_r[DW-2:0], ~trial[DW]};
        end
      end
      MD_FIX: begin
        done_nxt = 1'b1;
        unique case (op_r)
          MD_MUL:  res_nxt = acc_r;
          MD_DIV:  res_nxt = zero_r ? '0 : (negq_r ? DW'(-q_r) : q_r);
          MD_MOD:  res_nxt = zero_r ? '0 : (nega_r ? DW'(-acc_r) : acc_r);
          default: res_nxt = '0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    op_r   <= op_nxt;
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
    d_r    <= d_nxt;
    negq_r <= negq_nxt;
    nega_r <= nega_nxt;
    zero_r <= zero_nxt;
    res_r  <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

FILE: sv/postfix_stack_evaluator_unit.sv
`timescale 1ns / 1ps
// postfix_stack_evaluator_unit: stack machine for postfix integer code,
// stack and variables in psev_ram, mul/div/mod in psev_muldiv; uses psev_pkg
//
//  channel   dir  handshake          payload
//  in_item   in   valid/ready        req_type, operand_value, var_index, op_code
//  out_item  out  valid/ready        result_value, overflow_seen, underflow_seen
//
// one item at a time: push const and write var complete on acceptance, push
// var and read var first read the variable store, apply pops b and then a,
// and mul/div/mod run one bit per cycle in the shared iterative unit
// after reset every variable is cleared to zero, ready low
// a result waits in the output register; finish and read var hold until free

module postfix_stack_evaluator_unit #(
  parameter int STACK_DEPTH = psev_pkg::STACK_DEPTH_DEF,
  parameter int VAR_COUNT   = psev_pkg::VAR_COUNT_DEF,
  parameter int DATA_WIDTH  = psev_pkg::DATA_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  psev_in_if.sink    in_item,
  psev_out_if.source out_item
);
  import psev_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int SAW   = STACK_DEPTH > 1 ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int VAW   = VAR_COUNT > 1 ? $clog2(VAR_COUNT) : 1;
  localparam int SHW   = $clog2(DATA_WIDTH);

  st_t              state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             unf_r, unf_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic             idx_ok_r, idx_ok_nxt;
  logic             hit_r, hit_nxt;
  logic [DW-1:0]    b_r, b_nxt;
  logic [VAW-1:0]   clr_r, clr_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [EXT_W-1:0] out_val_r, out_val_nxt;
  logic             out_ovf_r, out_ovf_nxt;
  logic             out_unf_r, out_unf_nxt;

  logic             s_we, s_re;
  logic [SAW-1:0]   s_waddr, s_raddr;
  logic [DW-1:0]    s_wdata, s_rdata;
  logic             v_we, v_re;
  logic [VAW-1:0]   v_waddr, v_raddr;
  logic [DW-1:0]    v_wdata, v_rdata;

  md_req_t          md_req;
  logic             md_done;
  logic [DW-1:0]    md_result;

  logic             accept, slot_free, in_idx_ok, is_md;
  logic             push_en, pop_en, push_ok, pop_ok;
  logic [DW-1:0]    push_data, opnd_ext, a_val, alu_res;
  logic             load_out, clear_flags;
  logic [DW-1:0]    load_val;
  logic             shift_ok;
  logic [SHW-1:0]   sh_amt;

  assign in_item.ready = (state_r == ST_IDLE);
  assign accept        = in_item.valid && in_item.ready;
  assign slot_free     = !out_valid_r || out_item.ready;
  assign opnd_ext      = DW'(in_item.operand_value);
  assign in_idx_ok     = 32'(in_item.var_index) < 32'(VAR_COUNT);
  assign push_ok       = cnt_r < CNT_W'(STACK_DEPTH);
  assign pop_ok        = cnt_r != '0;
  assign a_val         = hit_r ? s_rdata : '0;
  assign is_md         = (op_r == OP_MUL) || (op_r == OP_DIV) || (op_r == OP_MOD);

  // simple operators, a from the stack read, b from the first pop
  assign sh_amt   = b_r[SHW-1:0];
  assign shift_ok = !b_r[DW-1] && (b_r < DW'(DATA_WIDTH));

  always_comb begin
    unique case (op_r)
      OP_ADD:  alu_res = a_val + b_r;
      OP_SUB:  alu_res = a_val - b_r;
      OP_AND:  alu_res = a_val & b_r;
      OP_OR:   alu_res = a_val | b_r;
      OP_XOR:  alu_res = a_val ^ b_r;
      OP_SHL:  alu_res = shift_ok ? (a_val << sh_amt) : '0;
      OP_SHR:  alu_res = shift_ok ? DW'($signed(a_val) >>> sh_amt) : {DW{a_val[DW-1]}};
      OP_LOR:  alu_res = DW'((a_val == DW'(1)) || (b_r == DW'(1)));
      OP_LAND: alu_res = DW'((a_val == DW'(1)) && (b_r == DW'(1)));
      OP_EQ:   alu_res = DW'(a_val == b_r);
      OP_NE:   alu_res = DW'(a_val != b_r);
      OP_GT:   alu_res = DW'($signed(b_r) < $signed(a_val));
      OP_LT:   alu_res = DW'($signed(a_val) < $signed(b_r));
      OP_GE:   alu_res = DW'(!($signed(a_val) < $signed(b_r)));
      OP_LE:   alu_res = DW'(!($signed(b_r) < $signed(a_val)));
      default: alu_res = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == VAW'(VAR_COUNT - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          priority case (in_item.req_type)
            REQ_PUSH_VAR: state_nxt = ST_PUSHV;
            REQ_APPLY:    state_nxt = ST_POPB;
            REQ_FINISH:   state_nxt = ST_FIN;
            REQ_READ_VAR: state_nxt = ST_RDV;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PUSHV:  state_nxt = ST_IDLE;
      ST_POPB:   state_nxt = ST_POPA;
      ST_POPA:   state_nxt = is_md ? ST_MULDIV : ST_IDLE;
      ST_MULDIV: if (md_done) state_nxt = ST_IDLE;
      ST_FIN:    if (slot_free) state_nxt = ST_IDLE;
      ST_RDV:    if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    push_en     = 1'b0;
    push_data   = '0;
    pop_en      = 1'b0;
    load_out    = 1'b0;
    load_val    = '0;
    clear_flags = 1'b0;
    v_we        = 1'b0;
    v_waddr     = VAW'(in_item.var_index);
    v_wdata     = opnd_ext;
    v_re        = 1'b0;
    v_raddr     = VAW'(in_item.var_index);
    op_nxt      = op_r;
    idx_ok_nxt  = idx_ok_r;
    b_nxt       = b_r;
    clr_nxt     = clr_r;
    md_req      = '{start: 1'b0, op: MD_MUL};
    unique case (state_r)
      ST_CLEAR: begin
        v_we    = 1'b1;
        v_waddr = clr_r;
        v_wdata = '0;
        clr_nxt = clr_r + VAW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          op_nxt     = in_item.op_code;
          idx_ok_nxt = in_idx_ok;
          priority case (in_item.req_type)
            REQ_PUSH_CONST: begin
              push_en   = 1'b1;
              push_data = opnd_ext;
            end
            REQ_PUSH_VAR, REQ_READ_VAR: v_re = 1'b1;
            REQ_APPLY, REQ_FINISH:      pop_en = 1'b1;
            REQ_WRITE_VAR:              v_we = in_idx_ok;
            default: ;
          endcase
        end
      end
      ST_PUSHV: begin
        push_en   = 1'b1;
        push_data = idx_ok_r ? v_rdata : '0;
      end
      ST_POPB: begin
        b_nxt  = a_val;
        pop_en = 1'b1;
      end
      ST_POPA: begin
        if (is_md) begin
          md_req.start = 1'b1;
          md_req.op    = (op_r == OP_MUL) ? MD_MUL : ((op_r == OP_DIV) ? MD_DIV : MD_MOD);
        end else begin
          push_en   = 1'b1;
          push_data = alu_res;
        end
      end
      ST_MULDIV: begin
        push_en   = md_done;
        push_data = md_result;
      end
      ST_FIN: begin
        load_out    = slot_free;
        load_val    = a_val;
        clear_flags = slot_free;
      end
      ST_RDV: begin
        load_out = slot_free;
        load_val = idx_ok_r ? v_rdata : '0;
      end
      default: ;
    endcase
  end

  // stack pointer and sticky flags
  always_comb begin
    s_we    = push_en && push_ok;
    s_waddr = SAW'(cnt_r);
    s_wdata = push_data;
    s_re    = pop_en && pop_ok;
    s_raddr = SAW'(cnt_r - CNT_W'(1));
    hit_nxt = pop_en ? pop_ok : hit_r;
    cnt_nxt = cnt_r;
    if (s_we) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (s_re) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    ovf_nxt = clear_flags ? 1'b0 : (ovf_r || (push_en && !push_ok));
    unf_nxt = clear_flags ? 1'b0 : (unf_r || (pop_en && !pop_ok));
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_item.ready;
    out_val_nxt   = out_val_r;
    out_ovf_nxt   = out_ovf_r;
    out_unf_nxt   = out_unf_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = EXT_W'(load_val);
      out_ovf_nxt   = ovf_r;
      out_unf_nxt   = unf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      unf_r       <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      unf_r       <= unf_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r      <= op_nxt;
    idx_ok_r  <= idx_ok_nxt;
    hit_r     <= hit_nxt;
    b_r       <= b_nxt;
    out_val_r <= out_val_nxt;
    out_ovf_r <= out_ovf_nxt;
    out_unf_r <= out_unf_nxt;
  end

  assign out_item.valid          = out_valid_r;
  assign out_item.result_value   = $signed(out_val_r);
  assign out_item.overflow_seen  = out_ovf_r;
  assign out_item.underflow_seen = out_unf_r;

  psev_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  psev_ram #(.WIDTH(DW), .DEPTH(VAR_COUNT)) u_vars (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .re    (v_re),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  psev_muldiv #(.DATA_WIDTH(DW)) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .a      (a_val),
    .b      (b_r),
    .done   (md_done),
    .result (md_result)
  );

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_md_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> state_r == ST_MULDIV)
    else $error("divider finished outside its wait state");

  a_full_push_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.req_type == REQ_PUSH_CONST && !push_ok)
      |=> ovf_r && $stable(cnt_r))
    else $error("push onto full stack not flagged");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && slot_free) |=> !ovf_r && !unf_r && out_valid_r)
    else $error("finish did not clear flags");
`endif

endmodule
